/* sv/polyphase_interpolator_core_defines.svh */
// assertion macros for the core rtl file
`ifndef POLYPHASE_INTERPOLATOR_CORE_DEFINES_SVH
`define POLYPHASE_INTERPOLATOR_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define PIC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define PIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/pic_pkg.sv */
package pic_pkg;

    localparam int MAX_TAPS    = 32;
    localparam int MAX_PHASES  = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int ACC_W       = 40;
    localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;

    localparam int TABLE_DEPTH = MAX_TAPS * MAX_PHASES;
    localparam int LINE_AW     = $clog2(MAX_TAPS);
    localparam int COEF_AW     = $clog2(TABLE_DEPTH);
    localparam int PH_W        = $clog2(MAX_PHASES);
    localparam int FILL_W      = $clog2(MAX_TAPS + 1);
    localparam int HALF_MAX    = MAX_TAPS / 2;

    // configuration registers
    localparam int HT_W      = 5;
    localparam int NPH_W     = 4;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_TAPS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASES    = 1'b1;

    // input item kinds
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    typedef struct packed {
        logic                          op;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_sample;
        logic [7:0]                    coef_index;
        logic signed [COEF_BITS-1:0]   coef_value;
    } t_in;

    typedef struct packed {
        logic signed [ACC_W-1:0] out_value;
        logic [2:0]              out_phase;
        logic                    out_last;
    } t_out;

    // control traveling with one product through the mac pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

/* sv/pic_ram.sv */
module pic_ram #(
    parameter int ADDR_W = 5,
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/pic_mac.sv */
module pic_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pic_pkg::t_mac_ctl                    i_ctl,
    input  logic [pic_pkg::SAMPLE_BITS-1:0]      i_sample,
    input  logic [pic_pkg::COEF_BITS-1:0]        i_coef,
    input  logic                                 i_take,
    output logic signed [pic_pkg::ACC_W-1:0]     o_acc,
    output logic                                 o_acc_valid
);

    pic_pkg::t_mac_ctl                   r_ctl1;
    pic_pkg::t_mac_ctl                   r_ctl2;
    logic signed [pic_pkg::PROD_W-1:0]   r_prod;
    logic signed [pic_pkg::ACC_W-1:0]    r_acc;
    logic                                r_acc_valid;

    // stage 1 lines up with the registered memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1      <= '0;
            r_ctl2      <= '0;
            r_acc_valid <= 1'b0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            if (r_ctl2.valid && r_ctl2.last) begin
                r_acc_valid <= 1'b1;
            end else if (i_take) begin
                r_acc_valid <= 1'b0;
            end
        end
    end

    // multiply, then accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= $signed(i_sample) * $signed(i_coef);
        if (r_ctl2.valid) begin
            r_acc <= (r_ctl2.first ? '0 : r_acc) + pic_pkg::ACC_W'(r_prod);
        end
    end

    assign o_acc       = r_acc;
    assign o_acc_valid = r_acc_valid;

endmodule

/* sv/polyphase_interpolator_core.sv */
// channel  | dir | handshake               | payload
// ---------+-----+-------------------------+------------------------------
// in       | in  | i_in_valid / o_in_ready | i_in  (pic_pkg::t_in)
// out      | out | o_out_valid/ i_out_ready| o_out (pic_pkg::t_out)
// cfg      | in  | i_cfg_we (no wait)      | i_cfg_index, i_cfg_data
//
// a coefficient transfer or a sample that does not fill the line leaves the core in idle
// a sample that fires runs every phase in turn: one product per cycle through the shared
//   multiplier while a phase issues, then a drain through the read, multiply and
//   accumulate registers before the phase result moves to the output register
// up to 32 taps and 8 phases
// reset is synchronous active low; no clearing pass, the fill count hides stale samples
// a stalled output holds the next phase in the accumulator; no transfer is taken
//   on the input side until the last phase is in the output register
module polyphase_interpolator_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  pic_pkg::t_in                     i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output pic_pkg::t_out                    o_out,
    input  logic                             i_cfg_we,
    input  logic [pic_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pic_pkg::CFG_W-1:0]        i_cfg_data
);

    `include "polyphase_interpolator_core_defines.svh"

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]                        r_state;
    logic [pic_pkg::HT_W-1:0]          r_half_taps;
    logic [pic_pkg::NPH_W-1:0]         r_phases;

    // circular delay line: r_head holds the newest sample
    logic [pic_pkg::LINE_AW-1:0]       r_head;
    logic [pic_pkg::FILL_W-1:0]        r_fill;
    logic [pic_pkg::FILL_W-1:0]        n_fill;

    // per-block loop bounds, latched at start
    logic [pic_pkg::LINE_AW-1:0]       r_taps_m1;
    logic [pic_pkg::NPH_W-1:0]         r_nph;
    logic [pic_pkg::PH_W-1:0]          r_nph_m1;

    // loop counters
    logic [pic_pkg::LINE_AW-1:0]       r_tap;
    logic [pic_pkg::PH_W-1:0]          r_ph;
    logic [pic_pkg::COEF_AW-1:0]       r_caddr;

    logic                              r_out_valid;
    pic_pkg::t_out                     r_out;

    logic                              in_xfer;
    logic                              sample_xfer;
    logic                              coef_xfer;
    logic [pic_pkg::HT_W-1:0]          ht_sat;
    logic [pic_pkg::NPH_W-1:0]         nph_sat;
    logic [pic_pkg::FILL_W-1:0]        taps;
    logic [pic_pkg::LINE_AW-1:0]       line_waddr;
    logic [pic_pkg::LINE_AW-1:0]       line_raddr;
    logic [pic_pkg::SAMPLE_BITS-1:0]   line_rdata;
    logic [pic_pkg::COEF_BITS-1:0]     coef_rdata;
    logic                              issue;
    pic_pkg::t_mac_ctl                 mac_ctl;
    logic signed [pic_pkg::ACC_W-1:0]  acc;
    logic                              acc_valid;
    logic                              out_load;
    logic                              last_phase;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign sample_xfer = in_xfer && (i_in.op == pic_pkg::OP_SAMPLE);
    assign coef_xfer   = in_xfer && (i_in.op == pic_pkg::OP_COEF);

    // clamp the registers into their legal ranges
    always_comb begin
        if (r_half_taps == '0) begin
            ht_sat = pic_pkg::HT_W'(1);
        end else if (r_half_taps > pic_pkg::HT_W'(pic_pkg::HALF_MAX)) begin
            ht_sat = pic_pkg::HT_W'(pic_pkg::HALF_MAX);
        end else begin
            ht_sat = r_half_taps;
        end
        if (r_phases == '0) begin
            nph_sat = pic_pkg::NPH_W'(1);
        end else if (r_phases > pic_pkg::NPH_W'(pic_pkg::MAX_PHASES)) begin
            nph_sat = pic_pkg::NPH_W'(pic_pkg::MAX_PHASES);
        end else begin
            nph_sat = r_phases;
        end
    end

    assign taps = pic_pkg::FILL_W'({ht_sat, 1'b0});

    // fill count saturates at the line depth
    assign n_fill = (r_fill < pic_pkg::FILL_W'(pic_pkg::MAX_TAPS)) ?
                    r_fill + pic_pkg::FILL_W'(1) : r_fill;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_taps <= pic_pkg::HT_W'(pic_pkg::HALF_MAX);
            r_phases    <= pic_pkg::NPH_W'(pic_pkg::MAX_PHASES);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pic_pkg::CFG_HALF_TAPS: r_half_taps <= i_cfg_data[pic_pkg::HT_W-1:0];
                pic_pkg::CFG_PHASES:    r_phases    <= i_cfg_data[pic_pkg::NPH_W-1:0];
                default: ;
            endcase
        end
    end

    // memory addressing: sample i steps old sits i entries behind the head
    assign line_waddr = r_head + pic_pkg::LINE_AW'(1);
    assign line_raddr = r_head - r_tap;
    assign issue      = (r_state == ST_ISSUE);

    pic_ram #(
        .ADDR_W (pic_pkg::LINE_AW),
        .DATA_W (pic_pkg::SAMPLE_BITS)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (sample_xfer),
        .i_waddr (line_waddr),
        .i_wdata (i_in.sample),
        .i_re    (issue),
        .i_raddr (line_raddr),
        .o_rdata (line_rdata)
    );

    // the address is 8 bits wide and the table has 256 words: every write lands
    pic_ram #(
        .ADDR_W (pic_pkg::COEF_AW),
        .DATA_W (pic_pkg::COEF_BITS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_xfer),
        .i_waddr (i_in.coef_index[pic_pkg::COEF_AW-1:0]),
        .i_wdata (i_in.coef_value),
        .i_re    (issue),
        .i_raddr (r_caddr),
        .o_rdata (coef_rdata)
    );

    always_comb begin
        mac_ctl.valid = issue;
        mac_ctl.first = (r_tap == '0);
        mac_ctl.last  = (r_tap == r_taps_m1);
    end

    pic_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (mac_ctl),
        .i_sample    (line_rdata),
        .i_coef      (coef_rdata),
        .i_take      (out_load),
        .o_acc       (acc),
        .o_acc_valid (acc_valid)
    );

    // finished phase moves into the output register once it is free
    assign out_load   = (r_state == ST_DRAIN) && acc_valid && (!r_out_valid || i_out_ready);
    assign last_phase = (r_ph == r_nph_m1);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_fill  <= '0;
            r_tap   <= '0;
            r_ph    <= '0;
            r_caddr <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (sample_xfer) begin
                        r_head <= line_waddr;
                        if (i_in.last_sample) begin
                            // stream ends: sample kept, line logically emptied
                            r_fill <= '0;
                        end else begin
                            r_fill <= n_fill;
                            if (n_fill >= taps) begin
                                r_state <= ST_ISSUE;
                            end
                        end
                        r_taps_m1 <= pic_pkg::LINE_AW'(taps - pic_pkg::FILL_W'(1));
                        r_nph     <= nph_sat;
                        r_nph_m1  <= pic_pkg::PH_W'(nph_sat - pic_pkg::NPH_W'(1));
                        r_tap     <= '0;
                        r_ph      <= '0;
                        r_caddr   <= '0;
                    end
                end
                ST_ISSUE: begin
                    if (mac_ctl.last) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_tap   <= r_tap + pic_pkg::LINE_AW'(1);
                        r_caddr <= r_caddr + pic_pkg::COEF_AW'(r_nph);
                    end
                end
                ST_DRAIN: begin
                    if (out_load) begin
                        if (last_phase) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_ISSUE;
                            r_tap   <= '0;
                            r_ph    <= r_ph + pic_pkg::PH_W'(1);
                            r_caddr <= pic_pkg::COEF_AW'(r_ph) + pic_pkg::COEF_AW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.out_value <= acc;
            r_out.out_phase <= 3'(r_ph);
            r_out.out_last  <= last_phase;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `PIC_ASSERT_SAME(a_issue_no_pending, i_clk, i_rst_n, r_state == ST_ISSUE, !acc_valid, "issue with unread accumulator")
    `PIC_ASSERT_SAME(a_tap_in_range, i_clk, i_rst_n, r_state == ST_ISSUE, r_tap <= r_taps_m1, "tap counter past tap count")
    `PIC_ASSERT_SAME(a_phase_in_range, i_clk, i_rst_n, r_state != ST_IDLE, r_ph <= r_nph_m1, "phase counter past phase count")
    `PIC_ASSERT_SAME(a_acc_only_drain, i_clk, i_rst_n, acc_valid, r_state == ST_DRAIN, "accumulator done outside drain")
    `PIC_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, sample_xfer && i_in.last_sample, r_fill == '0 && r_state == ST_IDLE, "last sample did not empty the line")

endmodule
